[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define GDSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define GDSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/gdsc_pkg.sv]
// ----------------------------------------------------------------------------
// gdsc_pkg
// Shared types and constants of the greedy-dual cache policy block.
// ----------------------------------------------------------------------------
package gdsc_pkg;

  localparam int ENTRIES   = 32;
  localparam int FRAC_BITS = 24;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int DVD_W     = 32 + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DVD_W + 1);

  localparam logic [1:0] MODE_GD    = 2'd0;
  localparam logic [1:0] MODE_GDS   = 2'd1;
  localparam logic [1:0] MODE_GDSF  = 2'd2;
  localparam logic [1:0] MODE_LFUDA = 2'd3;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  localparam logic [1:0]  MODE_RESET = MODE_GDSF;
  localparam logic [39:0] CAP_RESET  = 40'd1073741824;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] size;
    logic [63:0] prio;
    logic [31:0] hits;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic [31:0] numer;
    logic [31:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic       hit;
    logic       admitted;
    logic       refused;
    logic [5:0] evicted;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_MISS, S_EV_RD, S_EV_CMP, S_EV_DEC,
    S_TERM, S_DIV, S_WR, S_OUT
  } state_e;

endpackage

[sv/greedy_dual_size_cache_policy.sv]
// ----------------------------------------------------------------------------
// greedy_dual_size_cache_policy
// Greedy-dual byte-capacity cache policy (GD, GDS, GDSF, LFUDA modes).
// ----------------------------------------------------------------------------
// Usage:
//   A request (object_id_i, object_size_i) is taken on in_valid_i & in_ready_o.
//   in_ready_o is high only while the sequencer idles; one request is worked
//   on at a time. Each request yields exactly one result on the out channel
//   (was_hit_o, admitted_o, refused_too_big_o, evicted_count_o), held in an
//   output register until out_ready_i takes it; the sequencer waits in its
//   output state while an earlier result is still pending.
//   Per request: the lookup does one RAM read and one compare per slot,
//   stopping at a matching id. A miss at or above the capacity is refused.
//   A hit reprices through the serial divider in GDS and GDSF modes; GD and
//   LFUDA skip the divider. A miss scans every slot for a victim and a free
//   slot, evicting and rescanning until the object fits or no entry is left,
//   and is then priced as a hit is. Reset clears slot valid bits, the
//   inflation level, byte count and stamp; no clearing pass is needed.
//   Configuration is written over the APB port (mode at 0x0, capacity at 0x8);
//   the user must do so only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module greedy_dual_size_cache_policy import gdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] object_id_i,
  input  logic [31:0] object_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        was_hit_o,
  output logic        admitted_o,
  output logic        refused_too_big_o,
  output logic [5:0]  evicted_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [31:0]        id_q, id_d, size_q, size_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic               have_free_q, have_free_d;
  logic               vic_q, vic_d;
  logic [IDX_W-1:0]   vic_idx_q, vic_idx_d;
  logic [63:0]        vic_prio_q, vic_prio_d;
  logic [31:0]        vic_age_q, vic_age_d, vic_size_q, vic_size_d;
  logic [CNT_W-1:0]   nvalid_q, nvalid_d;
  logic [31:0]        cnt_q, cnt_d;
  logic               admit_q, admit_d;
  logic [63:0]        term_q, term_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [63:0]        level_q, level_d;
  logic [39:0]        used_q, used_d;
  logic [31:0]        stamp_q, stamp_d;
  logic [1:0]         mode_q;
  logic [39:0]        cap_q;
  result_t            res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  entry_t   rdata, wdata;
  logic     we;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [31:0] age;
  logic [40:0] need;
  logic [64:0] sum;
  logic        fits, last;
  logic        cfg_wr;

  gdsc_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_idx_q),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  gdsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign age  = stamp_q - rdata.stamp;
  assign need = {1'b0, used_q} + {9'b0, size_q};
  assign fits = (need <= {1'b0, cap_q}) && (nvalid_q < CNT_W'(ENTRIES));
  assign last = (idx_q == IDX_W'(ENTRIES - 1));
  assign sum  = {1'b0, level_q} + {1'b0, term_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    id_d        = id_q;
    size_d      = size_q;
    wr_idx_d    = wr_idx_q;
    free_idx_d  = free_idx_q;
    have_free_d = have_free_q;
    vic_d       = vic_q;
    vic_idx_d   = vic_idx_q;
    vic_prio_d  = vic_prio_q;
    vic_age_d   = vic_age_q;
    vic_size_d  = vic_size_q;
    nvalid_d    = nvalid_q;
    cnt_d       = cnt_q;
    admit_d     = admit_q;
    term_d      = term_q;
    valid_d     = valid_q;
    level_d     = level_q;
    used_d      = used_q;
    stamp_d     = stamp_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    wdata       = '0;
    div_req     = '0;
    in_ready_o  = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d    = object_id_i;
          size_d  = object_size_i;
          idx_d   = '0;
          res_d   = '0;
          state_d = S_LK_RD;
        end
      end
      S_LK_RD: state_d = S_LK_CMP;
      S_LK_CMP: begin
        if (valid_q[idx_q] && rdata.id == id_q) begin
          wr_idx_d = idx_q;
          if (rdata.size == size_q) begin
            // hit: bump count in frequency modes, then reprice
            cnt_d   = (mode_q[1] && rdata.hits != '1) ? rdata.hits + 1'b1 : rdata.hits;
            admit_d = 1'b0;
            state_d = S_TERM;
          end else begin
            // size changed: drop the stale entry, go on as a miss
            valid_d[idx_q] = 1'b0;
            used_d         = used_q - {8'b0, rdata.size};
            state_d        = S_MISS;
          end
        end else if (last) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_LK_RD;
        end
      end
      S_MISS: begin
        if ({8'b0, size_q} >= cap_q) begin
          res_d.refused = 1'b1;
          state_d       = S_OUT;
        end else begin
          idx_d       = '0;
          vic_d       = 1'b0;
          have_free_d = 1'b0;
          nvalid_d    = '0;
          state_d     = S_EV_RD;
        end
      end
      S_EV_RD: state_d = S_EV_CMP;
      S_EV_CMP: begin
        if (valid_q[idx_q]) begin
          nvalid_d = nvalid_q + 1'b1;
          if (!vic_q || rdata.prio < vic_prio_q ||
              (rdata.prio == vic_prio_q && age > vic_age_q)) begin
            vic_d      = 1'b1;
            vic_idx_d  = idx_q;
            vic_prio_d = rdata.prio;
            vic_age_d  = age;
            vic_size_d = rdata.size;
          end
        end else if (!have_free_q) begin
          have_free_d = 1'b1;
          free_idx_d  = idx_q;
        end
        if (last) begin
          state_d = S_EV_DEC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_EV_RD;
        end
      end
      S_EV_DEC: begin
        if (fits || !vic_q) begin
          if (!fits) begin
            used_d = '0;
          end
          wr_idx_d = free_idx_q;
          cnt_d    = 32'd1;
          admit_d  = 1'b1;
          state_d  = S_TERM;
        end else begin
          // evict the lowest priority entry, inflate L, and rescan
          valid_d[vic_idx_q] = 1'b0;
          used_d             = used_q - {8'b0, vic_size_q};
          level_d            = vic_prio_q;
          res_d.evicted      = res_q.evicted + 1'b1;
          idx_d              = '0;
          vic_d              = 1'b0;
          have_free_d        = 1'b0;
          nvalid_d           = '0;
          state_d            = S_EV_RD;
        end
      end
      S_TERM: begin
        case (mode_q)
          MODE_GD: begin
            term_d  = 64'(1) << FRAC_BITS;
            state_d = S_WR;
          end
          MODE_LFUDA: begin
            term_d  = 64'(cnt_q) << FRAC_BITS;
            state_d = S_WR;
          end
          MODE_GDS, MODE_GDSF: begin
            div_req.start = 1'b1;
            div_req.numer = (mode_q == MODE_GDS) ? 32'd1 : cnt_q;
            div_req.denom = (size_q == '0) ? 32'd1 : size_q;
            state_d       = S_DIV;
          end
          default: state_d = S_WR;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          term_d  = 64'(div_rsp.quot);
          state_d = S_WR;
        end
      end
      S_WR: begin
        we          = 1'b1;
        wdata.id    = id_q;
        wdata.size  = size_q;
        wdata.hits  = cnt_q;
        wdata.stamp = stamp_q;
        wdata.prio  = sum[64] ? '1 : sum[63:0];
        stamp_d     = stamp_q + 1'b1;
        if (admit_q) begin
          valid_d[wr_idx_q] = 1'b1;
          used_d            = used_q + {8'b0, size_q};
          res_d.admitted    = 1'b1;
        end else begin
          res_d.hit = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[3])
      REG_MODE: prdata = {62'b0, mode_q};
      REG_CAP:  prdata = {24'b0, cap_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      level_q     <= '0;
      used_q      <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RESET;
      cap_q       <= CAP_RESET;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      level_q     <= level_d;
      used_q      <= used_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr[3] == REG_MODE) begin
        mode_q <= pwdata[1:0];
      end
      if (cfg_wr && paddr[3] == REG_CAP) begin
        cap_q <= pwdata[39:0];
      end
    end
  end

  // datapath registers hold without reset
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    id_q        <= id_d;
    size_q      <= size_d;
    wr_idx_q    <= wr_idx_d;
    free_idx_q  <= free_idx_d;
    have_free_q <= have_free_d;
    vic_q       <= vic_d;
    vic_idx_q   <= vic_idx_d;
    vic_prio_q  <= vic_prio_d;
    vic_age_q   <= vic_age_d;
    vic_size_q  <= vic_size_d;
    nvalid_q    <= nvalid_d;
    cnt_q       <= cnt_d;
    admit_q     <= admit_d;
    term_q      <= term_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign was_hit_o         = out_q.hit;
  assign admitted_o        = out_q.admitted;
  assign refused_too_big_o = out_q.refused;
  assign evicted_count_o   = out_q.evicted;

endmodule

[sv/gdsc_ram.sv]
// ----------------------------------------------------------------------------
// gdsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/gdsc_div.sv]
// ----------------------------------------------------------------------------
// gdsc_div
// Restoring divider, one quotient bit per cycle: (numer << FRAC_BITS) / denom.
// ----------------------------------------------------------------------------
module gdsc_div import gdsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DVD_W-1:0]  sh_q, sh_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       den_q, den_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [32:0]       trial;

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, sh_q[DVD_W-1]};
    if (req_i.start) begin
      sh_d   = {req_i.numer, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      den_d  = req_i.denom;
      cnt_d  = DCNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
        sh_d  = {sh_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        sh_d  = {sh_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

[sv/gdsc_checker.sv]
// ----------------------------------------------------------------------------
// gdsc_checker
// Port-level checks of the cache policy block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       was_hit_o,
  input logic       admitted_o,
  input logic       refused_too_big_o,
  input logic [5:0] evicted_count_o
);

  `GDSC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `GDSC_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  `GDSC_ASSERT_NOW(a_hit_clean, out_valid_o && was_hit_o, !admitted_o && !refused_too_big_o && evicted_count_o == 6'd0)
  `GDSC_ASSERT_NOW(a_refuse_clean, out_valid_o && refused_too_big_o, !admitted_o && evicted_count_o == 6'd0)

endmodule

bind greedy_dual_size_cache_policy gdsc_checker u_gdsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .was_hit_o         (was_hit_o),
  .admitted_o        (admitted_o),
  .refused_too_big_o (refused_too_big_o),
  .evicted_count_o   (evicted_count_o)
);
